@@ hdl/sms_pkg.sv @@
`default_nettype none

package sms_pkg;

    localparam int MAX_LEN_DEF = 64;

    localparam int SYM_W  = 8;
    localparam int CLW    = 7;
    localparam int FRAC_W = 16;
    localparam int SCORE_W = FRAC_W + 1;

    localparam logic [1:0] ACT_FIRST   = 2'd0;
    localparam logic [1:0] ACT_SECOND  = 2'd1;
    localparam logic [1:0] ACT_COMPUTE = 2'd2;

    localparam logic [1:0] REG_COMPLETE_LENGTH = 2'd0;
    localparam logic [1:0] REG_PAD_CODE        = 2'd1;

    typedef struct packed {
        logic load_first;
        logic load_second;
        logic init;
        logic step;
        logic div_init;
        logic div_step;
        logic finish;
    } sms_cmd_t;

    typedef struct packed {
        logic empty;
        logic diag_end;
        logic last_shift;
        logic div_last;
        logic res_pending;
    } sms_status_t;

endpackage

`default_nettype wire

@@ hdl/sliding_match_score_core.sv @@
`default_nettype none

// Channel   Handshake                 Payload
// request   req_valid / req_stall     action, symbol
// result    res_valid / res_stall     best_matches, score, short_warning, overflowed
// config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A load request is taken whenever the core is idle, also while a result waits.
// A compute request holds the request channel until its result is written: each
// overlapping symbol pair of the two sequences is read from memory and then
// compared, and the score takes a 16-step divider.
// A compute request stalls while an earlier result has not been taken.
// Reset empties both sequences, sets complete_length to 1 and pad_code to 0.

module sliding_match_score_core import sms_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire logic [1:0]          action,
    input  wire logic [SYM_W-1:0]    symbol,
    output logic                     res_valid,
    input  wire logic                res_stall,
    output logic [CLW-1:0]           best_matches,
    output logic [SCORE_W-1:0]       score,
    output logic                     short_warning,
    output logic                     overflowed,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [SYM_W-1:0]    cfg_data
);

    sms_cmd_t    cmd;
    sms_status_t status;

    assign cfg_ready = 1'b1;

    sms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .action    (action),
        .status    (status),
        .cmd       (cmd),
        .req_stall (req_stall)
    );

    sms_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .symbol        (symbol),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .best_matches  (best_matches),
        .score         (score),
        .short_warning (short_warning),
        .overflowed    (overflowed)
    );

endmodule

`default_nettype wire

@@ hdl/sms_ctrl.sv @@
`default_nettype none

module sms_ctrl import sms_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    input  wire logic [1:0]  action,
    input  wire sms_status_t status,
    output sms_cmd_t         cmd,
    output logic             req_stall
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_DSET = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign req_stall = (state_reg != S_IDLE)
                    || (status.res_pending && (action == ACT_COMPUTE));
    assign accept = req_valid && !req_stall;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (action == ACT_FIRST))
                begin
                    cmd.load_first = 1'b1;
                end
                if (accept && (action == ACT_SECOND))
                begin
                    cmd.load_second = 1'b1;
                end
                if (accept && (action == ACT_COMPUTE))
                begin
                    cmd.init = 1'b1;
                    state_next = status.empty ? S_DSET : S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.step = 1'b1;
                if (status.diag_end && status.last_shift)
                begin
                    state_next = S_DSET;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_DSET:
            begin
                cmd.div_init = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/sms_datapath.sv @@
`default_nettype none

module sms_datapath import sms_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire sms_cmd_t            cmd,
    output sms_status_t              status,
    input  wire logic [SYM_W-1:0]    symbol,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [SYM_W-1:0]    cfg_data,
    output logic                     res_valid,
    input  wire logic                res_stall,
    output logic [CLW-1:0]           best_matches,
    output logic [SCORE_W-1:0]       score,
    output logic                     short_warning,
    output logic                     overflowed
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int SW = CW + 1;
    localparam int MW = (CW > CLW) ? CW : CLW;
    localparam int DCW = $clog2(FRAC_W);

    logic [SYM_W-1:0] first_mem [MAX_LEN];
    logic [SYM_W-1:0] second_mem [MAX_LEN];
    logic [SYM_W-1:0] first_q_reg;
    logic [SYM_W-1:0] second_q_reg;

    logic [CLW-1:0]   complete_length_reg, complete_length_next;
    logic [SYM_W-1:0] pad_code_reg, pad_code_next;
    logic [CW-1:0]    first_count_reg, first_count_next;
    logic [CW-1:0]    second_count_reg, second_count_next;
    logic             dropped_reg, dropped_next;
    logic             res_valid_reg, res_valid_next;

    logic             swap_reg, swap_next;
    logic [CW-1:0]    ns_reg, ns_next;
    logic [CW-1:0]    nl_reg, nl_next;
    logic [SW-1:0]    shift_reg, shift_next;
    logic [AW-1:0]    k_reg, k_next;
    logic [AW-1:0]    p_reg, p_next;
    logic [CW-1:0]    hits_reg, hits_next;
    logic [CW-1:0]    best_reg, best_next;
    logic             full_reg, full_next;
    logic [CLW-1:0]   rem_reg, rem_next;
    logic [FRAC_W-1:0] quo_reg, quo_next;
    logic [DCW-1:0]   div_cnt_reg, div_cnt_next;

    logic [CLW-1:0]     best_out_reg, best_out_next;
    logic [SCORE_W-1:0] score_reg, score_next;
    logic               warn_reg, warn_next;
    logic               ovf_reg, ovf_next;

    logic             wr_first;
    logic             wr_second;
    logic [AW-1:0]    first_addr;
    logic [AW-1:0]    second_addr;
    logic [CLW-1:0]   cl_eff;
    logic [CW-1:0]    hits_inc;
    logic [SW-1:0]    shift_inc;
    logic [CW-1:0]    ns_sel;
    logic [CLW:0]     rem_dbl;
    logic             diag_end;
    logic             last_shift;

    assign cl_eff = (complete_length_reg == '0) ? CLW'(1) : complete_length_reg;
    assign first_addr  = swap_reg ? p_reg : k_reg;
    assign second_addr = swap_reg ? k_reg : p_reg;
    assign hits_inc = hits_reg + CW'(first_q_reg == second_q_reg);
    assign shift_inc = shift_reg + SW'(1);
    assign ns_sel = (first_count_reg > second_count_reg) ? second_count_reg : first_count_reg;
    assign rem_dbl = {rem_reg, 1'b0};
    assign diag_end = ((CW'(k_reg) + CW'(1)) == ns_reg) || ((CW'(p_reg) + CW'(1)) == nl_reg);
    assign last_shift = (shift_reg + SW'(2)) >= (SW'(ns_reg) + SW'(nl_reg));

    assign wr_first  = cmd.load_first && (symbol != pad_code_reg)
                    && (first_count_reg != CW'(MAX_LEN));
    assign wr_second = cmd.load_second && (symbol != pad_code_reg)
                    && (second_count_reg != CW'(MAX_LEN));

    assign status.empty = (first_count_reg == '0) || (second_count_reg == '0);
    assign status.diag_end = diag_end;
    assign status.last_shift = last_shift;
    assign status.div_last = (div_cnt_reg == DCW'(FRAC_W - 1));
    assign status.res_pending = res_valid_reg;

    assign res_valid = res_valid_reg;
    assign best_matches = best_out_reg;
    assign score = score_reg;
    assign short_warning = warn_reg;
    assign overflowed = ovf_reg;

    always_comb
    begin
        complete_length_next = complete_length_reg;
        pad_code_next = pad_code_reg;
        first_count_next = first_count_reg;
        second_count_next = second_count_reg;
        dropped_next = dropped_reg;
        res_valid_next = res_valid_reg;
        swap_next = swap_reg;
        ns_next = ns_reg;
        nl_next = nl_reg;
        shift_next = shift_reg;
        k_next = k_reg;
        p_next = p_reg;
        hits_next = hits_reg;
        best_next = best_reg;
        full_next = full_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        div_cnt_next = div_cnt_reg;
        best_out_next = best_out_reg;
        score_next = score_reg;
        warn_next = warn_reg;
        ovf_next = ovf_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_COMPLETE_LENGTH: complete_length_next = cfg_data[CLW-1:0];
                REG_PAD_CODE:        pad_code_next = cfg_data;
                default:             ;
            endcase
        end

        if (cmd.load_first && (symbol != pad_code_reg))
        begin
            if (wr_first)
            begin
                first_count_next = first_count_reg + CW'(1);
            end
            else
            begin
                dropped_next = 1'b1;
            end
        end

        if (cmd.load_second && (symbol != pad_code_reg))
        begin
            if (wr_second)
            begin
                second_count_next = second_count_reg + CW'(1);
            end
            else
            begin
                dropped_next = 1'b1;
            end
        end

        if (cmd.init)
        begin
            swap_next = first_count_reg > second_count_reg;
            ns_next = ns_sel;
            nl_next = (first_count_reg > second_count_reg) ? first_count_reg
                                                           : second_count_reg;
            shift_next = '0;
            k_next = AW'(ns_sel - CW'(1));
            p_next = '0;
            hits_next = '0;
            best_next = '0;
        end

        if (cmd.step)
        begin
            if (!diag_end)
            begin
                k_next = k_reg + AW'(1);
                p_next = p_reg + AW'(1);
                hits_next = hits_inc;
            end
            else
            begin
                if (hits_inc > best_reg)
                begin
                    best_next = hits_inc;
                end
                hits_next = '0;
                shift_next = shift_inc;
                if (shift_inc < SW'(ns_reg))
                begin
                    k_next = AW'(SW'(ns_reg) - SW'(1) - shift_inc);
                    p_next = '0;
                end
                else
                begin
                    k_next = '0;
                    p_next = AW'(shift_inc - (SW'(ns_reg) - SW'(1)));
                end
            end
        end

        if (cmd.div_init)
        begin
            full_next = MW'(best_reg) >= MW'(cl_eff);
            rem_next = (MW'(best_reg) >= MW'(cl_eff)) ? '0 : CLW'(best_reg);
            quo_next = '0;
            div_cnt_next = '0;
        end

        if (cmd.div_step)
        begin
            if (rem_dbl >= {1'b0, cl_eff})
            begin
                rem_next = CLW'(rem_dbl - {1'b0, cl_eff});
                quo_next = {quo_reg[FRAC_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = CLW'(rem_dbl);
                quo_next = {quo_reg[FRAC_W-2:0], 1'b0};
            end
            div_cnt_next = div_cnt_reg + DCW'(1);
        end

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        if (cmd.finish)
        begin
            best_out_next = CLW'(best_reg);
            score_next = full_reg ? {1'b1, {FRAC_W{1'b0}}} : {1'b0, quo_reg};
            warn_next = MW'(ns_reg) < MW'(cl_eff);
            ovf_next = dropped_reg;
            first_count_next = '0;
            second_count_next = '0;
            dropped_next = 1'b0;
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            complete_length_reg <= CLW'(1);
            pad_code_reg <= '0;
            first_count_reg <= '0;
            second_count_reg <= '0;
            dropped_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            complete_length_reg <= complete_length_next;
            pad_code_reg <= pad_code_next;
            first_count_reg <= first_count_next;
            second_count_reg <= second_count_next;
            dropped_reg <= dropped_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        swap_reg <= swap_next;
        ns_reg <= ns_next;
        nl_reg <= nl_next;
        shift_reg <= shift_next;
        k_reg <= k_next;
        p_reg <= p_next;
        hits_reg <= hits_next;
        best_reg <= best_next;
        full_reg <= full_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_cnt_reg <= div_cnt_next;
        best_out_reg <= best_out_next;
        score_reg <= score_next;
        warn_reg <= warn_next;
        ovf_reg <= ovf_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_first)
        begin
            first_mem[first_count_reg[AW-1:0]] <= symbol;
        end
        first_q_reg <= first_mem[first_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_second)
        begin
            second_mem[second_count_reg[AW-1:0]] <= symbol;
        end
        second_q_reg <= second_mem[second_addr];
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (first_count_reg <= CW'(MAX_LEN)) && (second_count_reg <= CW'(MAX_LEN)))
        else $error("sequence length beyond store size");

    a_walk_in_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> ((CW'(k_reg) < ns_reg) && (CW'(p_reg) < nl_reg)))
        else $error("walk left the overlap");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (rem_reg < cl_eff))
        else $error("division remainder out of range");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(cmd.finish))
        else $error("result raised without a finished compute");

    a_clear_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> ((first_count_reg == '0) && (second_count_reg == '0)
                        && !dropped_reg && (score_reg <= {1'b1, {FRAC_W{1'b0}}})))
        else $error("state not cleared after compute");

endmodule

`default_nettype wire
